### design/bpa_pkg.sv
// Shared field widths and operation codes for the buddy page allocator.
`default_nettype none
package bpa_pkg;
    localparam int OP_W    = 2;
    localparam int ORDER_W = 6;
    localparam int FADDR_W = 32;
    localparam int BASE_W  = 32;
    localparam int LEN_W   = 33;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_REBUILD = 2'd0;
    localparam t_op OP_ALLOC   = 2'd1;
    localparam t_op OP_FREE    = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RANGE_BASE   = 2'd0;
    localparam t_cfg_idx CFG_RANGE_LENGTH = 2'd1;
endpackage
`default_nettype wire

### design/buddy_page_allocator_top.sv
// Buddy page allocator: free lists per order in a node pool, one sequencer.
//
// Input stream s_axis carries one command transaction: rebuild, allocate or
// free. The block answers every command with exactly one m_axis transaction
// holding the block address and a success flag.
// The configuration channel writes range_base (index 0) and range_length
// (index 1); write only while the block is idle.
// One command is worked at a time; s_axis_tready is low until its result has
// been taken. The sequencer walks the pool memory for each command:
//   allocate: scans the lists upward, pops a block, pushes one half per split;
//   free: searches the buddy's list node by node, merging per order level;
//   rebuild: carves the range into aligned blocks and pushes each one.
// The pool entries are handed out through a fill count, so reset and rebuild
// need no clearing pass. Reset empties every list and the range registers.
// When the receiver stalls, the result holds on m_axis and no new command is
// taken until it is accepted.
`default_nettype none
module buddy_page_allocator_top #(
    parameter int MIN_ORDER_LOG = 12,
    parameter int MAX_ORDER_LOG = 22,
    parameter int PAGE_BYTES    = 4096,
    parameter int POOL_ENTRIES  = 1024,
    parameter int ADDR_BITS     = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire  [bpa_pkg::IN_W-1:0] s_axis_tdata,  // op, order, address
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [bpa_pkg::OUT_W-1:0] m_axis_tdata, // block_address, success, zero pad
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [1:0]               i_cfg_index,
    input  wire  [bpa_pkg::LEN_W-1:0] i_cfg_data
);
    import bpa_pkg::*;

    localparam int NUM_LISTS = MAX_ORDER_LOG - MIN_ORDER_LOG + 1;
    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int NODE_W    = $clog2(POOL_ENTRIES + 1);
    localparam int IDX_W     = $clog2(POOL_ENTRIES);
    localparam int PG_LOG    = $clog2(PAGE_BYTES);
    localparam int PW        = ADDR_BITS - PG_LOG;
    localparam int CW        = (ADDR_BITS + 1 > 34) ? ADDR_BITS + 1 : 34;
    localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_ENTRIES);
    localparam logic [ORDER_W-1:0] MINO = ORDER_W'(MIN_ORDER_LOG);
    localparam logic [ORDER_W-1:0] MAXO = ORDER_W'(MAX_ORDER_LOG);
    localparam logic [CW-1:0] PG_MASK = CW'(PAGE_BYTES - 1);
    localparam logic [CW-1:0] MIN_SZ  = CW'(1) << MIN_ORDER_LOG;
    localparam logic [CW-1:0] LIMIT   = CW'(1) << ADDR_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RB_CHK, S_RB_ORD, S_AL_SCAN, S_AL_POP, S_AL_SPLIT,
        S_FR_CHK, S_RM_RD, S_RM_CMP, S_RM_GIVE, S_PUSH_RD, S_PUSH_WR, S_DONE
    } t_state;

    t_state r_state, r_ret;
    logic [NODE_W-1:0]  r_head [NUM_LISTS];
    logic [NODE_W-1:0]  r_spare, r_fill, r_n, r_prev;
    logic [NODE_W-1:0]  r_steps;
    logic [PW-1:0]      r_page_mem [POOL_ENTRIES];
    logic [NODE_W-1:0]  r_link_mem [POOL_ENTRIES];
    logic [PW-1:0]      r_page_q;
    logic [NODE_W-1:0]  r_link_q;
    logic [BASE_W-1:0]  r_base;
    logic [LEN_W-1:0]   r_len;
    logic [CW-1:0]      r_aligned, r_end, r_cur_a, r_rem, r_addr, r_buddy, r_pa;
    logic [ORDER_W-1:0] r_ord, r_cur, r_o;
    logic [LIST_W-1:0]  r_pl;
    logic [FADDR_W-1:0] r_res_addr;
    logic               r_res_ok, r_ovalid;

    t_op                w_op;
    logic [ORDER_W-1:0] w_order, w_ord;
    logic [FADDR_W-1:0] w_address;
    logic [CW-1:0]      w_end, w_al, w_sz, w_buddy, w_fa;
    logic [LIST_W-1:0]  w_cur_l, w_ord_l;
    logic               w_match, w_fits;
    logic [IDX_W-1:0]   w_raddr, w_lk_wa, w_pg_wa;
    logic [NODE_W-1:0]  w_lk_wd;
    logic               w_lk_we, w_pg_we;

    assign w_op      = s_axis_tdata[1:0];
    assign w_order   = s_axis_tdata[7:2];
    assign w_address = s_axis_tdata[39:8];
    assign w_ord     = (w_order < MINO) ? MINO : w_order;
    assign w_end     = CW'(r_base) + CW'(r_len);
    assign w_al      = (CW'(r_base) + PG_MASK) & ~PG_MASK;
    assign w_sz      = CW'(1) << r_o;
    assign w_fits    = ((r_cur_a & (w_sz - CW'(1))) == '0) && (w_sz <= r_rem);
    assign w_buddy   = r_addr ^ (CW'(1) << r_ord);
    assign w_fa      = CW'(w_address) & ~PG_MASK;
    assign w_cur_l   = LIST_W'(r_cur - MINO);
    assign w_ord_l   = LIST_W'(r_ord - MINO);
    assign w_match   = ((CW'(r_page_q) << PG_LOG) == r_buddy);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_res_ok, r_res_addr};

    always_comb begin
        w_raddr = r_n[IDX_W-1:0];
        w_lk_we = 1'b0;
        w_lk_wa = r_n[IDX_W-1:0];
        w_lk_wd = r_spare;
        w_pg_we = 1'b0;
        w_pg_wa = r_spare[IDX_W-1:0];
        case (r_state)
            S_AL_SCAN: w_raddr = r_head[w_cur_l][IDX_W-1:0];
            S_AL_POP:  w_lk_we = 1'b1;
            S_RM_CMP: begin
                w_lk_we = w_match && (r_prev != NIL);
                w_lk_wa = r_prev[IDX_W-1:0];
                w_lk_wd = r_link_q;
            end
            S_RM_GIVE: w_lk_we = 1'b1;
            S_PUSH_RD: w_raddr = r_spare[IDX_W-1:0];
            S_PUSH_WR: begin
                w_lk_we = 1'b1;
                w_lk_wa = r_spare[IDX_W-1:0];
                w_lk_wd = r_head[r_pl];
                w_pg_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_lk_we) r_link_mem[w_lk_wa] <= w_lk_wd;
        if (w_pg_we) r_page_mem[w_pg_wa] <= r_pa[PG_LOG +: PW];
        r_link_q <= r_link_mem[w_raddr];
        r_page_q <= r_page_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            for (int i = 0; i < NUM_LISTS; i++) r_head[i] <= NIL;
            r_spare   <= '0;
            r_fill    <= '0;
            r_ovalid  <= 1'b0;
            r_base    <= '0;
            r_len     <= '0;
            r_aligned <= '0;
            r_end     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RANGE_BASE:   r_base <= i_cfg_data[BASE_W-1:0];
                    CFG_RANGE_LENGTH: r_len  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_res_addr <= '0;
                        r_res_ok   <= 1'b0;
                        r_ord      <= w_ord;
                        r_cur      <= w_ord;
                        r_state    <= S_DONE;
                        case (w_op)
                            OP_REBUILD: begin
                                for (int i = 0; i < NUM_LISTS; i++) r_head[i] <= NIL;
                                r_spare  <= '0;
                                r_fill   <= '0;
                                r_res_ok <= 1'b1;
                                if (w_al >= ((w_end > LIMIT) ? LIMIT : w_end)) begin
                                    r_aligned <= '0;
                                    r_end     <= '0;
                                end else begin
                                    r_aligned <= w_al;
                                    r_end     <= (w_end > LIMIT) ? LIMIT : w_end;
                                    r_cur_a   <= w_al;
                                    r_rem     <= ((w_end > LIMIT) ? LIMIT : w_end) - w_al;
                                    r_state   <= S_RB_CHK;
                                end
                            end
                            OP_ALLOC: begin
                                if (w_ord <= MAXO) r_state <= S_AL_SCAN;
                            end
                            OP_FREE: begin
                                if (w_address != '0 && w_ord <= MAXO) begin
                                    r_addr  <= w_fa;
                                    r_state <= S_FR_CHK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RB_CHK: begin
                    if (r_rem >= MIN_SZ) begin
                        r_o     <= MAXO;
                        r_state <= S_RB_ORD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RB_ORD: begin
                    if (r_o > MINO && !w_fits) begin
                        r_o <= r_o - 6'd1;
                    end else begin
                        r_pl    <= LIST_W'(r_o - MINO);
                        r_pa    <= r_cur_a;
                        r_cur_a <= r_cur_a + w_sz;
                        r_rem   <= r_rem - w_sz;
                        r_ret   <= S_RB_CHK;
                        r_state <= S_PUSH_RD;
                    end
                end
                S_AL_SCAN: begin
                    if (r_cur > MAXO) begin
                        r_state <= S_DONE;
                    end else if (r_head[w_cur_l] == NIL) begin
                        r_cur <= r_cur + 6'd1;
                    end else begin
                        r_n     <= r_head[w_cur_l];
                        r_state <= S_AL_POP;
                    end
                end
                S_AL_POP: begin
                    r_head[w_cur_l] <= r_link_q;
                    r_spare    <= r_n;
                    r_addr     <= CW'(r_page_q) << PG_LOG;
                    r_res_addr <= FADDR_W'((CW'(r_page_q) << PG_LOG));
                    r_res_ok   <= 1'b1;
                    r_state    <= S_AL_SPLIT;
                end
                S_AL_SPLIT: begin
                    if (r_cur > r_ord) begin
                        r_cur   <= r_cur - 6'd1;
                        r_pl    <= LIST_W'(r_cur - 6'd1 - MINO);
                        r_pa    <= r_addr + (CW'(1) << (r_cur - 6'd1));
                        r_ret   <= S_AL_SPLIT;
                        r_state <= S_PUSH_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FR_CHK: begin
                    if (r_ord < MAXO && w_buddy >= r_aligned && w_buddy < r_end) begin
                        r_buddy <= w_buddy;
                        r_prev  <= NIL;
                        r_n     <= r_head[w_ord_l];
                        r_steps <= '0;
                        r_state <= S_RM_RD;
                    end else begin
                        r_pl     <= w_ord_l;
                        r_pa     <= r_addr;
                        r_res_ok <= 1'b1;
                        r_ret    <= S_DONE;
                        r_state  <= S_PUSH_RD;
                    end
                end
                S_RM_RD: begin
                    if (r_n == NIL || r_steps == NODE_W'(POOL_ENTRIES)) begin
                        r_pl     <= w_ord_l;
                        r_pa     <= r_addr;
                        r_res_ok <= 1'b1;
                        r_ret    <= S_DONE;
                        r_state  <= S_PUSH_RD;
                    end else begin
                        r_state <= S_RM_CMP;
                    end
                end
                S_RM_CMP: begin
                    if (w_match) begin
                        if (r_prev == NIL) r_head[w_ord_l] <= r_link_q;
                        r_state <= S_RM_GIVE;
                    end else begin
                        r_prev  <= r_n;
                        r_n     <= r_link_q;
                        r_steps <= r_steps + NODE_W'(1);
                        r_state <= S_RM_RD;
                    end
                end
                S_RM_GIVE: begin
                    r_spare <= r_n;
                    if (r_buddy < r_addr) r_addr <= r_buddy;
                    r_ord   <= r_ord + 6'd1;
                    r_state <= S_FR_CHK;
                end
                S_PUSH_RD: begin
                    r_state <= (r_spare == NIL) ? r_ret : S_PUSH_WR;
                end
                S_PUSH_WR: begin
                    if (r_spare >= r_fill) begin
                        r_spare <= r_spare + NODE_W'(1);
                        r_fill  <= r_spare + NODE_W'(1);
                    end else begin
                        r_spare <= r_link_q;
                    end
                    r_head[r_pl] <= r_spare;
                    r_state      <= r_ret;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the buddy page allocator: stream commands in, check every result.
`default_nettype none
module tb;
    import bpa_pkg::*;

    localparam int MIN_ORD = 12;
    localparam int MAX_ORD = 22;
    localparam int PAGE = 4096;
    localparam int POOL = 1024;
    localparam int NLISTS = MAX_ORD - MIN_ORD + 1;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class alloc_scoreboard;
        longint unsigned cfg_base, cfg_len, base_al, end_r;
        int unsigned head[NLISTS];
        int unsigned page_of[POOL];
        int unsigned link_of[POOL];
        int unsigned spare;
        logic [32:0] pending[$];
        longint unsigned live_addr[$];
        int unsigned live_ord[$];
        int errors, checked, allocs_ok, frees_ok;

        function void clear_lists();
            for (int i = 0; i < NLISTS; i++) head[i] = POOL;
            for (int i = 0; i < POOL; i++) begin
                link_of[i] = i + 1;
                page_of[i] = 0;
            end
            spare = 0;
        endfunction

        function void reset_state();
            cfg_base = 0;
            cfg_len = 0;
            base_al = 0;
            end_r = 0;
            clear_lists();
        endfunction

        function void give_back(int unsigned n);
            link_of[n] = spare;
            spare = n;
        endfunction

        function void push_blk(int unsigned lst, longint unsigned a);
            int unsigned n;
            n = spare;
            if (n >= POOL || lst >= NLISTS) return;
            spare = link_of[n];
            page_of[n] = a / PAGE;
            link_of[n] = head[lst];
            head[lst] = n;
        endfunction

        function bit pop_blk(int unsigned lst, output longint unsigned a);
            int unsigned n;
            a = 0;
            n = head[lst];
            if (n >= POOL) return 0;
            head[lst] = link_of[n];
            a = longint'(page_of[n]) * PAGE;
            give_back(n);
            return 1;
        endfunction

        function bit remove_blk(int unsigned lst, longint unsigned a);
            int unsigned prev, n;
            prev = POOL;
            n = head[lst];
            for (int s = 0; s < POOL && n < POOL; s++) begin
                if (longint'(page_of[n]) * PAGE == a) begin
                    if (prev < POOL) link_of[prev] = link_of[n];
                    else head[lst] = link_of[n];
                    give_back(n);
                    return 1;
                end
                prev = n;
                n = link_of[n];
            end
            return 0;
        endfunction

        function void carve();
            longint unsigned lim, e, al, cur, rem, sz;
            int unsigned o;
            lim = 64'd1 << 32;
            e = cfg_base + cfg_len;
            al = ((cfg_base + PAGE - 1) / PAGE) * PAGE;
            clear_lists();
            if (e > lim) e = lim;
            if (al >= e) begin
                base_al = 0;
                end_r = 0;
                return;
            end
            base_al = al;
            end_r = e;
            cur = al;
            rem = e - al;
            while (rem >= (64'd1 << MIN_ORD)) begin
                o = MAX_ORD;
                while (o > MIN_ORD) begin
                    sz = 64'd1 << o;
                    if ((cur & (sz - 1)) == 0 && sz <= rem) break;
                    o--;
                end
                sz = 64'd1 << o;
                push_blk(o - MIN_ORD, cur);
                cur += sz;
                rem -= sz;
            end
        endfunction

        function void note(t_op op, logic [5:0] ord_in, logic [31:0] addr_in);
            int unsigned ord, cur;
            longint unsigned a, buddy;
            logic [31:0] res;
            logic ok;
            ord = ord_in;
            res = 0;
            ok = 0;
            if (ord < MIN_ORD) ord = MIN_ORD;
            if (op == OP_REBUILD) begin
                carve();
                live_addr.delete();
                live_ord.delete();
                ok = 1;
            end else if (op == OP_ALLOC) begin
                if (ord <= MAX_ORD) begin
                    cur = ord;
                    while (cur <= MAX_ORD && head[cur - MIN_ORD] >= POOL) cur++;
                    if (cur <= MAX_ORD && pop_blk(cur - MIN_ORD, a)) begin
                        while (cur > ord) begin
                            cur--;
                            push_blk(cur - MIN_ORD, a + (64'd1 << cur));
                        end
                        res = a[31:0];
                        ok = 1;
                        allocs_ok++;
                        live_addr.push_back(a);
                        live_ord.push_back(ord);
                    end
                end
            end else if (op == OP_FREE) begin
                if (addr_in != 0 && ord <= MAX_ORD) begin
                    a = addr_in - (addr_in % PAGE);
                    while (ord < MAX_ORD) begin
                        buddy = a ^ (64'd1 << ord);
                        if (buddy < base_al || buddy >= end_r) break;
                        if (!remove_blk(ord - MIN_ORD, buddy)) break;
                        if (buddy < a) a = buddy;
                        ord++;
                    end
                    push_blk(ord - MIN_ORD, a);
                    ok = 1;
                    frees_ok++;
                end
            end
            pending.push_back({ok, res});
        endfunction

        function void check(logic [OUT_W-1:0] d);
            logic [32:0] e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d[32:0]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e[31:0]) begin
                $display("%0t: block_address expected %h actual %h", $time, e[31:0], d[31:0]);
                errors++;
            end
            if (d[32] !== e[32]) begin
                $display("%0t: success expected %b actual %b", $time, e[32], d[32]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [LEN_W-1:0] i_cfg_data = '0;

    alloc_scoreboard sb;
    int idle_pct = 0, stall_pct = 0, quiet = 0, sent = 0, phases = 0;

    buddy_page_allocator_top u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_cmd(t_op op, logic [5:0] ord, logic [31:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {addr, ord, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(op, ord, addr);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [LEN_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_RANGE_BASE) sb.cfg_base = val[31:0];
        else sb.cfg_len = val;
    endtask

    task automatic set_range(logic [31:0] b, logic [32:0] l);
        drain();
        write_reg(CFG_RANGE_BASE, {1'b0, b});
        write_reg(CFG_RANGE_LENGTH, l);
        send_cmd(OP_REBUILD, 6'($urandom), $urandom);
        phases++;
    endtask

    task automatic random_cmd();
        int unsigned r, k;
        logic [5:0] ord;
        r = $urandom_range(99);
        ord = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(MAX_ORD, MIN_ORD));
        if (r < 45) begin
            send_cmd(OP_ALLOC, ord, $urandom);
        end else if (r < 85 && sb.live_addr.size() != 0) begin
            k = $urandom_range(sb.live_addr.size() - 1);
            send_cmd(OP_FREE, 6'(sb.live_ord[k]), sb.live_addr[k][31:0]);
            sb.live_addr.delete(k);
            sb.live_ord.delete(k);
        end else if (r < 95) begin
            send_cmd(OP_FREE, ord, $urandom);
        end else if (r < 98) begin
            send_cmd(OP_UNUSED, 6'($urandom), $urandom);
        end else begin
            send_cmd(OP_REBUILD, 6'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [31:0] b;
        logic [32:0] l;
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        set_range(32'h0012_3456, 33'h0080_0000);
        send_cmd(OP_ALLOC, 6'd0, 32'hFFFF_FFFF);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        send_cmd(OP_ALLOC, 6'd22, 32'h0);
        send_cmd(OP_ALLOC, 6'd23, 32'h0);
        send_cmd(OP_ALLOC, 6'd63, 32'h0);
        send_cmd(OP_FREE, 6'd12, 32'h0);
        send_cmd(OP_FREE, 6'd63, 32'h0012_4000);
        send_cmd(OP_FREE, 6'd0, 32'h0012_4ABC);
        send_cmd(OP_FREE, 6'd12, 32'hF000_0000);
        send_cmd(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
        set_range(32'h0, 33'h4000);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        send_cmd(OP_ALLOC, 6'd13, 32'h0);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        set_range(32'hFFFF_F001, 33'h0);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        set_range(32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        set_range(32'h0, 33'h1_0000_0000);
        send_cmd(OP_ALLOC, 6'd12, 32'h0);
        send_cmd(OP_FREE, 6'd12, 32'h0000_0000);
        send_cmd(OP_FREE, 6'd12, 32'h0040_1000);

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            case (p)
                0: begin b = 32'h0; l = 33'h1_0000_0000; end
                5: begin b = 32'hFFFF_FFFF; l = 33'h1_FFFF_FFFF; end
                9: begin b = 32'h0; l = 33'h0; end
                default: begin
                    b = $urandom;
                    l = 33'($urandom_range(32'h0400_0000));
                end
            endcase
            set_range(b, l);
            repeat (150) random_cmd();
        end

        drain();
        $display("tb: %0d commands over %0d range settings, %0d results checked",
                 sent, phases, sb.checked);
        $display("tb: %0d successful allocations, %0d accepted frees",
                 sb.allocs_ok, sb.frees_ok);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
design/bpa_pkg.sv
design/buddy_page_allocator_top.sv
bench/tb.sv
